@@ design/tefu_pkg.sv @@
// ----------------------------------------------------------------------------
// tefu_pkg
// Shared types and constants for the task event flag unit: request and
// status codes, per-task wait flags and the response flag group.
// ----------------------------------------------------------------------------
package tefu_pkg;

   // Default sizing of the flag store
   localparam int TEFU_TASK_COUNT  = 32;
   localparam int TEFU_EVENT_WIDTH = 32;

   // Fixed port widths
   localparam int TEFU_TASK_ID_W = 5;
   localparam int TEFU_MASK_W    = 32;

   // Request codes
   typedef enum logic [1:0] {
      REQ_SEND    = 2'd0,
      REQ_RECEIVE = 2'd1,
      REQ_CANCEL  = 2'd2,
      REQ_UNKNOWN = 2'd3
   } tefu_req_type;

   // Response status codes
   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_NO_EVENTS = 3'd1,
      ST_WAITING   = 3'd2,
      ST_BAD_TASK  = 3'd3,
      ST_BAD_MASK  = 3'd4,
      ST_TIMEOUT   = 3'd5
   } tefu_status_type;

   // Per-task wait flags
   typedef struct packed {
      logic waiting;
      logic all_mode;
   } tefu_wait_type;

   // Response flag group
   typedef struct packed {
      tefu_status_type status;
      logic            woken;
   } tefu_rsp_type;

endpackage

@@ design/tefu_eval.sv @@
// ----------------------------------------------------------------------------
// tefu_eval
// Combinational evaluation of one request against one task's entry: gives
// the entry's next value, the delivered bits and the response flags.
// ----------------------------------------------------------------------------
module tefu_eval #(
   parameter int EW = 32
) (
   input  tefu_pkg::tefu_req_type  req_type,
   input  logic                    task_ok,
   input  logic [EW-1:0]           mask,
   input  logic                    wait_any,
   input  logic                    no_wait,
   input  logic [EW-1:0]           pend,
   input  logic [EW-1:0]           wbits,
   input  tefu_pkg::tefu_wait_type wflags,
   output logic [EW-1:0]           pend_next,
   output logic [EW-1:0]           wbits_next,
   output tefu_pkg::tefu_wait_type wflags_next,
   output logic [EW-1:0]           got,
   output tefu_pkg::tefu_rsp_type  rsp
);
   import tefu_pkg::*;

   logic [EW-1:0] pend_or;
   logic [EW-1:0] send_match;
   logic [EW-1:0] recv_match;
   logic          hit_send;
   logic          hit_recv;
   logic          mask_zero;

   // any: some wanted bit present; all: every wanted bit present
   function automatic logic cond_met(input logic [EW-1:0] match,
                                     input logic [EW-1:0] want,
                                     input logic          all);
      cond_met = all ? (match == want) : (|match);
   endfunction

   // Condition terms
   assign pend_or    = pend | mask;
   assign send_match = pend_or & wbits;
   assign recv_match = pend & mask;
   assign hit_send   = wflags.waiting && cond_met(send_match, wbits, wflags.all_mode);
   assign hit_recv   = cond_met(recv_match, mask, !wait_any);
   assign mask_zero  = (mask == '0);

   // Request decode
   always_comb begin
      pend_next   = pend;
      wbits_next  = wbits;
      wflags_next = wflags;
      got         = '0;
      rsp.status  = ST_OK;
      rsp.woken   = 1'b0;
      if (!task_ok) begin
         rsp.status = ST_BAD_TASK;
      end else begin
         unique case (req_type)
            REQ_SEND: begin
               if (mask_zero) begin
                  rsp.status = ST_BAD_MASK;
               end else begin
                  pend_next = pend_or;
                  if (hit_send) begin
                     got         = send_match;
                     pend_next   = pend_or & ~send_match;
                     wbits_next  = '0;
                     wflags_next = '0;
                     rsp.woken   = 1'b1;
                  end
               end
            end
            REQ_RECEIVE: begin
               if (mask_zero) begin
                  rsp.status = ST_BAD_MASK;
               end else begin
                  // a new receive always ends an earlier wait
                  wbits_next  = '0;
                  wflags_next = '0;
                  if (hit_recv) begin
                     got       = recv_match;
                     pend_next = pend & ~recv_match;
                  end else if (no_wait) begin
                     rsp.status = ST_NO_EVENTS;
                  end else begin
                     wbits_next           = mask;
                     wflags_next.waiting  = 1'b1;
                     wflags_next.all_mode = !wait_any;
                     rsp.status           = ST_WAITING;
                  end
               end
            end
            REQ_CANCEL: begin
               if (wflags.waiting) begin
                  wbits_next  = '0;
                  wflags_next = '0;
                  rsp.status  = ST_TIMEOUT;
               end
            end
            REQ_UNKNOWN: begin
               rsp.status = ST_OK;
            end
         endcase
      end
   end

endmodule

@@ design/task_event_flag_unit.sv @@
// ----------------------------------------------------------------------------
// task_event_flag_unit
// Per-task event flags with any/all waits: send, receive and wait cancel.
//
//  Channel   Handshake          Ports
//  --------  -----------------  ----------------------------------------------
//  request   start / busy       req_type, req_task_id, req_event_mask,
//                                req_wait_any, req_no_wait
//  response  rsp_strobe (1 cyc) rsp_status, rsp_received_bits, rsp_task_woken
//
//  One request per cycle while busy is low; the response strobe follows the
//  input register, one pass through the entry logic and the response register.
//  The state of a task is read and rewritten in the same cycle, so a request
//  sees every earlier one without forwarding.
//  Synchronous reset clears all flags at once; busy is high during reset and
//  for the cycle after it, and low otherwise.
//  The receiver cannot stall: each response is valid for exactly one cycle.
// ----------------------------------------------------------------------------
module task_event_flag_unit #(
   parameter int TASK_COUNT  = tefu_pkg::TEFU_TASK_COUNT,
   parameter int EVENT_WIDTH = tefu_pkg::TEFU_EVENT_WIDTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [1:0]                         req_type,
   input  logic [tefu_pkg::TEFU_TASK_ID_W-1:0] req_task_id,
   input  logic [tefu_pkg::TEFU_MASK_W-1:0]   req_event_mask,
   input  logic                               req_wait_any,
   input  logic                               req_no_wait,
   output logic                               rsp_strobe,
   output logic [2:0]                         rsp_status,
   output logic [tefu_pkg::TEFU_MASK_W-1:0]   rsp_received_bits,
   output logic                               rsp_task_woken
);
   import tefu_pkg::*;

   // Only tasks reachable through the id port and bits through the mask port
   localparam int TD = (TASK_COUNT < (1 << TEFU_TASK_ID_W)) ? TASK_COUNT
                                                             : (1 << TEFU_TASK_ID_W);
   localparam int IW = (TD > 1) ? $clog2(TD) : 1;
   localparam int EW = (EVENT_WIDTH < TEFU_MASK_W) ? EVENT_WIDTH : TEFU_MASK_W;

   // Flag store
   logic [EW-1:0] pend_ff   [TD];
   logic [EW-1:0] wbits_ff  [TD];
   tefu_wait_type wflags_ff [TD];

   // Input register
   logic          busy_ff;
   logic          req_vld_ff;
   tefu_req_type  req_type_ff;
   logic          task_ok_ff;
   logic [IW-1:0] idx_ff;
   logic [EW-1:0] mask_ff;
   logic          any_ff;
   logic          nowait_ff;

   // Response register
   logic                   rsp_strobe_ff;
   tefu_rsp_type           rsp_flags_ff;
   logic [TEFU_MASK_W-1:0] rsp_bits_ff;

   logic          accept_in;
   logic          task_ok_in;
   logic          entry_we;
   logic [EW-1:0] pend_rd;
   logic [EW-1:0] wbits_rd;
   tefu_wait_type wflags_rd;
   logic [EW-1:0] pend_in;
   logic [EW-1:0] wbits_in;
   tefu_wait_type wflags_in;
   logic [EW-1:0] got_in;
   tefu_rsp_type  rsp_flags_in;

   assign accept_in  = start && !busy_ff;
   assign task_ok_in = (9'(req_task_id) < 9'(TASK_COUNT));
   assign busy       = busy_ff;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b1;
         req_vld_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         busy_ff       <= 1'b0;
         req_vld_ff    <= accept_in;
         rsp_strobe_ff <= req_vld_ff;
      end
   end

   // Request payload capture
   always_ff @(posedge clock) begin
      if (accept_in) begin
         req_type_ff <= tefu_req_type'(req_type);
         task_ok_ff  <= task_ok_in;
         idx_ff      <= req_task_id[IW-1:0];
         mask_ff     <= req_event_mask[EW-1:0];
         any_ff      <= req_wait_any;
         nowait_ff   <= req_no_wait;
      end
   end

   // Entry read; a bad task id never writes and its read is masked in eval
   assign pend_rd   = pend_ff[idx_ff];
   assign wbits_rd  = wbits_ff[idx_ff];
   assign wflags_rd = wflags_ff[idx_ff];

   tefu_eval #(
      .EW (EW)
   ) u_eval (
      .req_type    (req_type_ff),
      .task_ok     (task_ok_ff),
      .mask        (mask_ff),
      .wait_any    (any_ff),
      .no_wait     (nowait_ff),
      .pend        (pend_rd),
      .wbits       (wbits_rd),
      .wflags      (wflags_rd),
      .pend_next   (pend_in),
      .wbits_next  (wbits_in),
      .wflags_next (wflags_in),
      .got         (got_in),
      .rsp         (rsp_flags_in)
   );

   assign entry_we = req_vld_ff && task_ok_ff;

   // Flag store update
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TD; i++) begin
            pend_ff[i]   <= '0;
            wbits_ff[i]  <= '0;
            wflags_ff[i] <= '0;
         end
      end else if (entry_we) begin
         pend_ff[idx_ff]   <= pend_in;
         wbits_ff[idx_ff]  <= wbits_in;
         wflags_ff[idx_ff] <= wflags_in;
      end
   end

   // Response payload
   always_ff @(posedge clock) begin
      if (req_vld_ff) begin
         rsp_flags_ff <= rsp_flags_in;
         rsp_bits_ff  <= TEFU_MASK_W'(got_in);
      end
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_status        = rsp_flags_ff.status;
   assign rsp_received_bits = rsp_bits_ff;
   assign rsp_task_woken    = rsp_flags_ff.woken;

   // Checks
   a_rsp_follows_req: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(req_vld_ff))
      else $error("response without a request in flight");

   a_woken_delivers: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_task_woken |-> rsp_status == ST_OK && rsp_received_bits != '0)
      else $error("wake without delivered bits");

   a_fail_no_bits: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_status == ST_NO_EVENTS || rsp_status == ST_WAITING ||
                     rsp_status == ST_BAD_TASK || rsp_status == ST_BAD_MASK ||
                     rsp_status == ST_TIMEOUT)
      |-> rsp_received_bits == '0 && !rsp_task_woken)
      else $error("bits delivered on a non-delivering response");

   a_wait_has_bits: assert property (@(posedge clock) disable iff (reset)
      entry_we && wflags_in.waiting |-> wbits_in != '0)
      else $error("wait started with an empty wait mask");

endmodule
